// ----- hw/rtl/thae_pkg.sv -----
// ----------------------------------------------------------------------------
// thae_pkg
// Shared types, widths and constants of the tilt/heading attitude estimator.
// ----------------------------------------------------------------------------
package thae_pkg;

  // Angle and datapath widths
  localparam int AngleW      = 16;
  localparam int CordicW     = 38;
  localparam int CordicSteps = 16;
  localparam int IterW       = $clog2(CordicSteps);
  localparam int ZW          = AngleW + 2;
  localparam int TrigW       = 18;
  localparam int SqrtW       = 48;
  localparam int DivW        = 26;
  localparam int RemW        = 12;
  localparam int StepCntW    = 5;
  localparam int CountW      = 11;
  localparam int SumW        = 26;
  localparam int TrigSumW    = 27;
  localparam int ProdW       = 33;
  localparam int CfgDataW    = 16;
  localparam int CfgIdxW     = 2;
  localparam int GainW       = 15;

  localparam int QuarterTurn = 16384;
  localparam int InvGainQ23  = 5094007;
  localparam int MaxWindow   = 1024;
  localparam int SqrtSteps   = 24;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TILT_GAIN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEAD_GAIN = 2'd2;

  typedef enum logic {
    CORDIC_VEC = 1'b0,
    CORDIC_ROT = 1'b1
  } cordic_mode_e;

  typedef enum logic {
    DS_SQRT = 1'b0,
    DS_DIV  = 1'b1
  } ds_mode_e;

  typedef struct packed {
    logic                     command;
    logic signed [15:0]       accel_x;
    logic signed [15:0]       accel_y;
    logic signed [15:0]       accel_z;
    logic signed [15:0]       mag_x;
    logic signed [15:0]       mag_y;
    logic                     sensor_online;
    logic                     calibration_done;
  } thae_in_t;

  typedef struct packed {
    logic signed [15:0]       roll_angle;
    logic signed [15:0]       pitch_angle;
    logic signed [15:0]       heading_angle;
    logic                     status;
    logic                     zero_collecting;
  } thae_out_t;

  typedef struct packed {
    logic                     start;
    cordic_mode_e             mode;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [AngleW-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [AngleW-1:0] angle;
    logic signed [TrigW-1:0]  sin;
    logic signed [TrigW-1:0]  cos;
  } cordic_rsp_t;

  typedef struct packed {
    logic                     start;
    ds_mode_e                 mode;
    logic [SqrtW-1:0]         radicand;
    logic [DivW-1:0]          dividend;
    logic [CountW-1:0]        divisor;
  } ds_req_t;

  typedef struct packed {
    logic                     done;
    logic [DivW-1:0]          value;
  } ds_rsp_t;

  // Rounded arctangent of 2^-i in binary angle units
  function automatic logic [AngleW-1:0] atan_step(input logic [IterW-1:0] i);
    logic [AngleW-1:0] a;
    unique case (i)
      4'd0:    a = 16'd8192;
      4'd1:    a = 16'd4836;
      4'd2:    a = 16'd2555;
      4'd3:    a = 16'd1297;
      4'd4:    a = 16'd651;
      4'd5:    a = 16'd326;
      4'd6:    a = 16'd163;
      4'd7:    a = 16'd81;
      4'd8:    a = 16'd41;
      4'd9:    a = 16'd20;
      4'd10:   a = 16'd10;
      4'd11:   a = 16'd5;
      4'd12:   a = 16'd3;
      4'd13:   a = 16'd1;
      4'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Sensor count scaled by 256 into the CORDIC width
  function automatic logic signed [CordicW-1:0] scale_sample(input logic signed [15:0] v);
    return {{(CordicW-24){v[15]}}, v, 8'h00};
  endfunction

  // Trig sum scaled by 256 into the CORDIC width
  function automatic logic signed [CordicW-1:0] scale_sum(
    input logic signed [TrigSumW-1:0] v
  );
    return {{(CordicW-TrigSumW-8){v[TrigSumW-1]}}, v, 8'h00};
  endfunction

endpackage

// ----- hw/rtl/thae_cordic.sv -----
// ----------------------------------------------------------------------------
// thae_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring gives atan2,
// rotation gives Q15 sine and cosine.
// ----------------------------------------------------------------------------
module thae_cordic
  import thae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [IterW-1:0]          iter_q, iter_d;
  cordic_mode_e              mode_q, mode_d;
  logic                      flip_q, flip_d;
  logic                      zero_q, zero_d;
  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]      z_q, z_d;

  logic signed [CordicW-1:0] dx, dy, x_rnd, y_rnd;
  logic signed [ZW-1:0]      step, quarter;
  logic signed [AngleW-1:0]  ang_flip;
  logic                      dir;
  logic signed [TrigW-1:0]   s_rnd, c_rnd;

  assign quarter  = ZW'(QuarterTurn);
  assign ang_flip = req_i.angle ^ {1'b1, {(AngleW-1){1'b0}}};

  // Start, prerotation and micro-rotation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    mode_d = mode_q;
    flip_d = flip_q;
    zero_d = zero_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    dx     = y_q >>> iter_q;
    dy     = x_q >>> iter_q;
    step   = $signed({2'b00, atan_step(iter_q)});
    dir    = (mode_q == CORDIC_VEC) ? (y_q > 0) : z_q[ZW-1];
    if (req_i.start) begin
      busy_d = 1'b1;
      iter_d = '0;
      mode_d = req_i.mode;
      if (req_i.mode == CORDIC_VEC) begin
        flip_d = 1'b0;
        zero_d = (req_i.x == 0) && (req_i.y == 0);
        if (req_i.x < 0) begin
          if (req_i.y >= 0) begin
            x_d = req_i.y;
            y_d = -req_i.x;
            z_d = quarter;
          end else begin
            x_d = -req_i.y;
            y_d = req_i.x;
            z_d = -quarter;
          end
        end else begin
          x_d = req_i.x;
          y_d = req_i.y;
          z_d = '0;
        end
      end else begin
        zero_d = 1'b0;
        x_d    = CordicW'(InvGainQ23);
        y_d    = '0;
        if (req_i.angle > AngleW'(QuarterTurn) || req_i.angle < -AngleW'(QuarterTurn)) begin
          flip_d = 1'b1;
          z_d    = ZW'(ang_flip);
        end else begin
          flip_d = 1'b0;
          z_d    = ZW'(req_i.angle);
        end
      end
    end else if (busy_q) begin
      if (dir) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + step;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - step;
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == IterW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    mode_q <= mode_d;
    flip_q <= flip_d;
    zero_q <= zero_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // Q15 rounding of the rotated vector, half up
  assign x_rnd = (x_q + CordicW'(128)) >>> 8;
  assign y_rnd = (y_q + CordicW'(128)) >>> 8;
  assign c_rnd = x_rnd[TrigW-1:0];
  assign s_rnd = y_rnd[TrigW-1:0];

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = zero_q ? '0 : z_q[AngleW-1:0];
  assign rsp_o.sin   = flip_q ? -s_rnd : s_rnd;
  assign rsp_o.cos   = flip_q ? -c_rnd : c_rnd;

endmodule

// ----- hw/rtl/thae_divsqrt.sv -----
// ----------------------------------------------------------------------------
// thae_divsqrt
// Radix-2 shift/subtract unit: integer square root or unsigned division,
// one result bit per cycle through one shared compare-subtract.
// ----------------------------------------------------------------------------
module thae_divsqrt
  import thae_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ds_req_t req_i,
  output ds_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  ds_mode_e            mode_q, mode_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [SqrtW-1:0]    v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [CountW-1:0]   div_q, div_d;

  logic [SqrtW-1:0]    sub_a, sub_b, t_sum;
  logic [SqrtW:0]      diff;
  logic                ge;
  logic [RemW-1:0]     rem_sh;
  logic [StepCntW-1:0] last;

  assign t_sum  = r_q + bit_q;
  assign rem_sh = {r_q[RemW-2:0], v_q[DivW-1]};
  assign sub_a  = (mode_q == DS_SQRT) ? v_q : SqrtW'(rem_sh);
  assign sub_b  = (mode_q == DS_SQRT) ? t_sum : SqrtW'(div_q);
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge     = !diff[SqrtW];
  assign last   = (mode_q == DS_SQRT) ? StepCntW'(SqrtSteps - 1) : StepCntW'(DivW - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      cnt_d  = '0;
      r_d    = '0;
      bit_d  = SqrtW'(1) << (SqrtW - 2);
      div_d  = req_i.divisor;
      v_d    = (req_i.mode == DS_SQRT) ? req_i.radicand : SqrtW'(req_i.dividend);
    end else if (busy_q) begin
      if (mode_q == DS_SQRT) begin
        // one root digit per cycle
        if (ge) begin
          v_d = diff[SqrtW-1:0];
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        // restoring division, one quotient bit per cycle
        r_d = ge ? diff[SqrtW-1:0] : SqrtW'(rem_sh);
        v_d = SqrtW'({v_q[DivW-2:0], ge});
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cnt_q  <= cnt_d;
    v_q    <= v_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    div_q  <= div_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = (mode_q == DS_SQRT) ? r_q[DivW-1:0] : v_q[DivW-1:0];

endmodule

// ----- hw/rtl/tilt_heading_attitude_estimator_top.sv -----
// ----------------------------------------------------------------------------
// tilt_heading_attitude_estimator_top
// Roll, pitch and heading from accelerometer and magnetometer samples, with
// zero-reference capture and first-order smoothing.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_ready_o   | thae_in_t
//  out     | output    | out_valid_o / out_ready_i | thae_out_t
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Per item: rezero or ignored samples go straight to output; tracking runs
//  radix-2 sqrt, three 16-step shared CORDIC passes and the filter; the zero
//  window swaps the filter for a rotation; closing adds two divides, a pass.
//  Reset is asynchronous, active low; configuration takes its defaults.
//  The next input transfer is taken while a result waits in the output
//  register; a stalled output holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module tilt_heading_attitude_estimator_top
  import thae_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  thae_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output thae_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int StW = 5;
  localparam logic [StW-1:0] S_IDLE       = 5'd0;
  localparam logic [StW-1:0] S_SQ1        = 5'd1;
  localparam logic [StW-1:0] S_SQ2        = 5'd2;
  localparam logic [StW-1:0] S_SQ3        = 5'd3;
  localparam logic [StW-1:0] S_SQRT_GO    = 5'd4;
  localparam logic [StW-1:0] S_SQRT_WAIT  = 5'd5;
  localparam logic [StW-1:0] S_ROLL_GO    = 5'd6;
  localparam logic [StW-1:0] S_ROLL_WAIT  = 5'd7;
  localparam logic [StW-1:0] S_PITCH_GO   = 5'd8;
  localparam logic [StW-1:0] S_PITCH_WAIT = 5'd9;
  localparam logic [StW-1:0] S_HEAD_GO    = 5'd10;
  localparam logic [StW-1:0] S_HEAD_WAIT  = 5'd11;
  localparam logic [StW-1:0] S_SC_GO      = 5'd12;
  localparam logic [StW-1:0] S_SC_WAIT    = 5'd13;
  localparam logic [StW-1:0] S_MR_GO      = 5'd14;
  localparam logic [StW-1:0] S_MR_WAIT    = 5'd15;
  localparam logic [StW-1:0] S_MP_GO      = 5'd16;
  localparam logic [StW-1:0] S_MP_WAIT    = 5'd17;
  localparam logic [StW-1:0] S_HO_GO      = 5'd18;
  localparam logic [StW-1:0] S_HO_WAIT    = 5'd19;
  localparam logic [StW-1:0] S_F1         = 5'd20;
  localparam logic [StW-1:0] S_F2         = 5'd21;
  localparam logic [StW-1:0] S_F3         = 5'd22;
  localparam logic [StW-1:0] S_F4         = 5'd23;
  localparam logic [StW-1:0] S_DONE       = 5'd24;

  logic [StW-1:0]             state_q, state_d;
  thae_in_t                   in_q, in_d;
  thae_out_t                  out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic [CountW-1:0]          win_len_q, win_len_d;
  logic [GainW-1:0]           tilt_gain_q, tilt_gain_d, head_gain_q, head_gain_d;

  logic signed [AngleW-1:0]   fr_q, fr_d, fp_q, fp_d, fh_q, fh_d;
  logic                       win_act_q, win_act_d, zero_rdy_q, zero_rdy_d;
  logic [CountW-1:0]          count_q, count_d;
  logic signed [SumW-1:0]     roll_sum_q, roll_sum_d, pitch_sum_q, pitch_sum_d;
  logic signed [TrigSumW-1:0] sin_sum_q, sin_sum_d, cos_sum_q, cos_sum_d;
  logic signed [AngleW-1:0]   roll_off_q, roll_off_d, pitch_off_q, pitch_off_d;
  logic signed [AngleW-1:0]   head_off_q, head_off_d;

  // scratch of the current sample
  logic signed [ProdW-1:0]    p_q, p_d;
  logic [31:0]                acc_q, acc_d;
  logic [SqrtSteps-1:0]       sqrt_q, sqrt_d;
  logic signed [AngleW-1:0]   roll_q, roll_d, pitch_q, pitch_d, head_q, head_d;

  cordic_req_t                c_req;
  cordic_rsp_t                c_rsp;
  ds_req_t                    d_req;
  ds_rsp_t                    d_rsp;

  logic signed [16:0]         mul_a;
  logic signed [15:0]         mul_b;
  logic signed [ProdW-1:0]    p_rnd;
  logic signed [AngleW-1:0]   inc;
  logic signed [AngleW-1:0]   cr, cp, ch, dh;
  logic signed [16:0]         diff_r, diff_p;
  logic [CountW-1:0]          len, cnt_new;
  logic                       start_win;
  logic signed [SumW-1:0]     mean_sum;
  logic [SumW-1:0]            mean_mag;
  logic [AngleW-1:0]          q16;

  thae_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (c_req),
    .rsp_o  (c_rsp)
  );

  thae_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (d_req),
    .rsp_o  (d_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Offset correction and filter differences
  assign cr     = roll_q - roll_off_q;
  assign cp     = pitch_q - pitch_off_q;
  assign ch     = head_q - head_off_q;
  assign dh     = ch - fh_q;
  assign diff_r = {cr[AngleW-1], cr} - {fr_q[AngleW-1], fr_q};
  assign diff_p = {cp[AngleW-1], cp} - {fp_q[AngleW-1], fp_q};
  assign p_rnd  = p_q + ProdW'(16384);
  assign inc    = p_rnd[30:15];

  // Window bookkeeping
  assign len       = (win_len_q == '0) ? CountW'(1) :
                     (win_len_q > CountW'(MaxWindow)) ? CountW'(MaxWindow) : win_len_q;
  assign start_win = !zero_rdy_q && !win_act_q;
  assign cnt_new   = (start_win ? '0 : count_q) + 1'b1;
  assign mean_sum  = (state_q == S_MP_GO || state_q == S_MP_WAIT) ? pitch_sum_q : roll_sum_q;
  assign mean_mag  = (mean_sum[SumW-1] ? -mean_sum : mean_sum) + SumW'(count_q >> 1);
  assign q16       = mean_sum[SumW-1] ? -d_rsp.value[AngleW-1:0] : d_rsp.value[AngleW-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ1: begin
        mul_a = {in_q.accel_y[15], in_q.accel_y};
        mul_b = in_q.accel_y;
      end
      S_SQ2: begin
        mul_a = {in_q.accel_z[15], in_q.accel_z};
        mul_b = in_q.accel_z;
      end
      S_F1: begin
        mul_a = diff_r;
        mul_b = {1'b0, tilt_gain_q};
      end
      S_F2: begin
        mul_a = diff_p;
        mul_b = {1'b0, tilt_gain_q};
      end
      S_F3: begin
        mul_a = {dh[AngleW-1], dh};
        mul_b = {1'b0, head_gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    p_d = mul_a * mul_b;
  end

  // Requests to the shared units
  always_comb begin
    c_req       = '0;
    c_req.mode  = CORDIC_VEC;
    d_req       = '0;
    d_req.mode  = DS_DIV;
    unique case (state_q)
      S_SQRT_GO: begin
        d_req.start    = 1'b1;
        d_req.mode     = DS_SQRT;
        d_req.radicand = {acc_q, 16'h0000};
      end
      S_ROLL_GO: begin
        c_req.start = 1'b1;
        c_req.x     = scale_sample(in_q.accel_z);
        c_req.y     = scale_sample(in_q.accel_y);
      end
      S_PITCH_GO: begin
        c_req.start = 1'b1;
        c_req.x     = CordicW'(sqrt_q);
        c_req.y     = -scale_sample(in_q.accel_x);
      end
      S_HEAD_GO: begin
        c_req.start = 1'b1;
        c_req.x     = scale_sample(in_q.mag_x);
        c_req.y     = scale_sample(in_q.mag_y);
      end
      S_SC_GO: begin
        c_req.start = 1'b1;
        c_req.mode  = CORDIC_ROT;
        c_req.angle = head_q;
      end
      S_MR_GO, S_MP_GO: begin
        d_req.start    = 1'b1;
        d_req.dividend = mean_mag;
        d_req.divisor  = count_q;
      end
      S_HO_GO: begin
        c_req.start = 1'b1;
        c_req.x     = scale_sum(cos_sum_q);
        c_req.y     = scale_sum(sin_sum_q);
      end
      default: begin
        c_req.start = 1'b0;
        d_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    win_len_d   = win_len_q;
    tilt_gain_d = tilt_gain_q;
    head_gain_d = head_gain_q;
    fr_d        = fr_q;
    fp_d        = fp_q;
    fh_d        = fh_q;
    win_act_d   = win_act_q;
    zero_rdy_d  = zero_rdy_q;
    count_d     = count_q;
    roll_sum_d  = roll_sum_q;
    pitch_sum_d = pitch_sum_q;
    sin_sum_d   = sin_sum_q;
    cos_sum_d   = cos_sum_q;
    roll_off_d  = roll_off_q;
    pitch_off_d = pitch_off_q;
    head_off_d  = head_off_q;
    acc_d       = acc_q;
    sqrt_d      = sqrt_q;
    roll_d      = roll_q;
    pitch_d     = pitch_q;
    head_d      = head_q;

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW:    win_len_d   = cfg_data_i[CountW-1:0];
        CFG_TILT_GAIN: tilt_gain_d = cfg_data_i[GainW-1:0];
        CFG_HEAD_GAIN: head_gain_d = cfg_data_i[GainW-1:0];
        default:       win_len_d   = win_len_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.command) begin
            // rezero clears offsets, sums and outputs
            fr_d        = '0;
            fp_d        = '0;
            fh_d        = '0;
            win_act_d   = 1'b0;
            zero_rdy_d  = 1'b0;
            count_d     = '0;
            roll_sum_d  = '0;
            pitch_sum_d = '0;
            sin_sum_d   = '0;
            cos_sum_d   = '0;
            roll_off_d  = '0;
            pitch_off_d = '0;
            head_off_d  = '0;
            state_d     = S_DONE;
          end else if (in_data_i.sensor_online && in_data_i.calibration_done) begin
            state_d = S_SQ1;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SQ1: state_d = S_SQ2;
      S_SQ2: begin
        acc_d   = p_q[31:0];
        state_d = S_SQ3;
      end
      S_SQ3: begin
        acc_d   = acc_q + p_q[31:0];
        state_d = S_SQRT_GO;
      end
      S_SQRT_GO: state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (d_rsp.done) begin
          sqrt_d  = d_rsp.value[SqrtSteps-1:0];
          state_d = S_ROLL_GO;
        end
      end
      S_ROLL_GO: state_d = S_ROLL_WAIT;
      S_ROLL_WAIT: begin
        if (c_rsp.done) begin
          roll_d  = c_rsp.angle;
          state_d = S_PITCH_GO;
        end
      end
      S_PITCH_GO: state_d = S_PITCH_WAIT;
      S_PITCH_WAIT: begin
        if (c_rsp.done) begin
          pitch_d = c_rsp.angle;
          state_d = S_HEAD_GO;
        end
      end
      S_HEAD_GO: state_d = S_HEAD_WAIT;
      S_HEAD_WAIT: begin
        if (c_rsp.done) begin
          head_d  = c_rsp.angle;
          state_d = (win_act_q || !zero_rdy_q) ? S_SC_GO : S_F1;
        end
      end
      S_SC_GO: state_d = S_SC_WAIT;
      S_SC_WAIT: begin
        // accumulate into the zero window, opening it if needed
        if (c_rsp.done) begin
          roll_sum_d  = (start_win ? '0 : roll_sum_q) + SumW'(roll_q);
          pitch_sum_d = (start_win ? '0 : pitch_sum_q) + SumW'(pitch_q);
          sin_sum_d   = (start_win ? '0 : sin_sum_q) + TrigSumW'(c_rsp.sin);
          cos_sum_d   = (start_win ? '0 : cos_sum_q) + TrigSumW'(c_rsp.cos);
          count_d     = cnt_new;
          win_act_d   = 1'b1;
          state_d     = (cnt_new >= len) ? S_MR_GO : S_DONE;
        end
      end
      S_MR_GO: state_d = S_MR_WAIT;
      S_MR_WAIT: begin
        if (d_rsp.done) begin
          roll_off_d = q16;
          state_d    = S_MP_GO;
        end
      end
      S_MP_GO: state_d = S_MP_WAIT;
      S_MP_WAIT: begin
        if (d_rsp.done) begin
          pitch_off_d = q16;
          state_d     = S_HO_GO;
        end
      end
      S_HO_GO: state_d = S_HO_WAIT;
      S_HO_WAIT: begin
        // circular mean closes the window
        if (c_rsp.done) begin
          head_off_d = c_rsp.angle;
          win_act_d  = 1'b0;
          zero_rdy_d = 1'b1;
          fr_d       = '0;
          fp_d       = '0;
          fh_d       = '0;
          state_d    = S_DONE;
        end
      end
      S_F1: state_d = S_F2;
      S_F2: begin
        fr_d    = fr_q + inc;
        state_d = S_F3;
      end
      S_F3: begin
        fp_d    = fp_q + inc;
        state_d = S_F4;
      end
      S_F4: begin
        fh_d    = fh_q + inc;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_d) begin
          out_d.roll_angle      = fr_q;
          out_d.pitch_angle     = fp_q;
          out_d.heading_angle   = fh_q;
          out_d.status          = zero_rdy_q;
          out_d.zero_collecting = win_act_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      win_len_q   <= CountW'(64);
      tilt_gain_q <= GainW'(3277);
      head_gain_q <= GainW'(1638);
      fr_q        <= '0;
      fp_q        <= '0;
      fh_q        <= '0;
      win_act_q   <= 1'b0;
      zero_rdy_q  <= 1'b0;
      count_q     <= '0;
      roll_sum_q  <= '0;
      pitch_sum_q <= '0;
      sin_sum_q   <= '0;
      cos_sum_q   <= '0;
      roll_off_q  <= '0;
      pitch_off_q <= '0;
      head_off_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      win_len_q   <= win_len_d;
      tilt_gain_q <= tilt_gain_d;
      head_gain_q <= head_gain_d;
      fr_q        <= fr_d;
      fp_q        <= fp_d;
      fh_q        <= fh_d;
      win_act_q   <= win_act_d;
      zero_rdy_q  <= zero_rdy_d;
      count_q     <= count_d;
      roll_sum_q  <= roll_sum_d;
      pitch_sum_q <= pitch_sum_d;
      sin_sum_q   <= sin_sum_d;
      cos_sum_q   <= cos_sum_d;
      roll_off_q  <= roll_off_d;
      pitch_off_q <= pitch_off_d;
      head_off_q  <= head_off_d;
    end
  end

  // payload and scratch
  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    out_q   <= out_d;
    p_q     <= p_d;
    acc_q   <= acc_d;
    sqrt_q  <= sqrt_d;
    roll_q  <= roll_d;
    pitch_q <= pitch_d;
    head_q  <= head_d;
  end

endmodule
